### hdl/aes128_block_decrypt_assert.svh
// Assertion macros for the checker file.
`ifndef AES128_BLOCK_DECRYPT_ASSERT_SVH
`define AES128_BLOCK_DECRYPT_ASSERT_SVH
`define AES_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define AES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### hdl/aesd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aesd_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned StoreDepth = 2 * (NumRounds + 1);
  localparam int unsigned KeyWords = 4 * (NumRounds + 1);
  localparam int unsigned RegIdxW = 1;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [RegIdxW-1:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } out_beat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_ROUND,
    ST_DONE
  } dec_state_e;

  typedef enum logic [1:0] {
    KS_IDLE,
    KS_RUN
  } ks_state_e;

  typedef struct packed {
    logic        wr;
    logic [4:0]  addr;
    logic [63:0] data;
  } ks_wr_t;

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xt(x);
    end
    return p;
  endfunction

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] ISBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam logic [3:0] SHIFT_SRC [16] = '{
    4'd0, 4'd13, 4'd10, 4'd7, 4'd4, 4'd1, 4'd14, 4'd11,
    4'd8, 4'd5, 4'd2, 4'd15, 4'd12, 4'd9, 4'd6, 4'd3
  };

endpackage
`default_nettype wire

### hdl/aesd_key_sched.sv
`timescale 1ns / 1ps
`default_nettype none
module aesd_key_sched (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [127:0]          key_i,
  output aesd_pkg::ks_wr_t           wr_o,
  output logic                       busy_o
);

  aesd_pkg::ks_state_e state_q, state_d;
  logic [127:0] w_q, w_d;
  logic [7:0]   rcon_q, rcon_d;
  logic [3:0]   rnd_q, rnd_d;
  logic         half_q, half_d;
  logic [31:0]  rot, sub, w4, w5, w6, w7;

  always_comb begin
    state_d = state_q;
    case (state_q)
      aesd_pkg::KS_IDLE: if (start_i) state_d = aesd_pkg::KS_RUN;
      aesd_pkg::KS_RUN:  if (half_q && rnd_q == 4'(aesd_pkg::NumRounds)) state_d = aesd_pkg::KS_IDLE;
      default:           state_d = aesd_pkg::KS_IDLE;
    endcase
  end

  assign rot = {w_q[23:0], w_q[31:24]};
  assign sub = {aesd_pkg::SBOX[rot[31:24]], aesd_pkg::SBOX[rot[23:16]],
                aesd_pkg::SBOX[rot[15:8]], aesd_pkg::SBOX[rot[7:0]]};
  assign w4 = w_q[127:96] ^ sub ^ {rcon_q, 24'h0};
  assign w5 = w_q[95:64] ^ w4;
  assign w6 = w_q[63:32] ^ w5;
  assign w7 = w_q[31:0] ^ w6;

  always_comb begin
    w_d = w_q;
    rcon_d = rcon_q;
    rnd_d = rnd_q;
    half_d = half_q;
    if (start_i) begin
      w_d = key_i;
      rcon_d = 8'h01;
      rnd_d = '0;
      half_d = 1'b0;
    end else if (state_q == aesd_pkg::KS_RUN) begin
      half_d = ~half_q;
      if (half_q) begin
        w_d = {w4, w5, w6, w7};
        rcon_d = aesd_pkg::xt(rcon_q);
        rnd_d = rnd_q + 4'd1;
      end
    end
  end

  always_comb begin
    wr_o.wr = (state_q == aesd_pkg::KS_RUN) && !start_i;
    wr_o.addr = {rnd_q, half_q};
    wr_o.data = half_q ? w_q[63:0] : w_q[127:64];
    busy_o = (state_q == aesd_pkg::KS_RUN) || start_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aesd_pkg::KS_IDLE;
      rnd_q <= '0;
      half_q <= 1'b0;
      rcon_q <= 8'h01;
    end else begin
      state_q <= start_i ? aesd_pkg::KS_RUN : state_d;
      rnd_q <= rnd_d;
      half_q <= half_d;
      rcon_q <= rcon_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

endmodule
`default_nettype wire

### hdl/aes128_block_decrypt.sv
`timescale 1ns / 1ps
`default_nettype none
// AES-128 decryption of one 128-bit block. A key write starts the key schedule,
// which fills all 22 entries of the round-key memory; in_stall_o stays high from
// the write until the schedule is done. A block is taken when in_valid_i is high
// and in_stall_o low, then runs one shared round unit in eleven steps (first key
// add with round 10, rounds 9 to 1, final key add), each made of two memory reads
// (high and low half of the round key) and the update. The result shows on
// out_valid_o once the last step is done and is held until taken; the next block
// is taken only after that, so a new block cannot start before the last is through.
module aes128_block_decrypt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire aesd_pkg::in_beat_t        in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output aesd_pkg::out_beat_t            out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [aesd_pkg::RegIdxW-1:0] cfg_idx_i,
  input  wire logic [aesd_pkg::CfgDataW-1:0] cfg_data_i
);

  logic [63:0] key_hi_q, key_lo_q;
  logic [127:0] key_new;
  logic ks_busy;
  aesd_pkg::ks_wr_t ks_wr;
  logic [63:0] rk_mem [aesd_pkg::StoreDepth];
  logic [63:0] rk_q;
  logic [4:0]  rd_addr;

  aesd_pkg::dec_state_e state_q, state_d;
  logic [127:0] st_q, st_d;
  logic [63:0]  kh_q;
  logic [3:0]   rnd_q, rnd_d;
  logic [1:0]   ph_q, ph_d;
  logic [127:0] ark, mix, shs;
  logic         last_round;

  always_comb begin
    key_new = {key_hi_q, key_lo_q};
    case (cfg_idx_i)
      aesd_pkg::REG_KEY_HIGH: key_new[127:64] = cfg_data_i;
      aesd_pkg::REG_KEY_LOW:  key_new[63:0] = cfg_data_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      key_hi_q <= key_new[127:64];
      key_lo_q <= key_new[63:0];
    end
  end

  aesd_key_sched u_ks (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_we_i),
    .key_i   (key_new),
    .wr_o    (ks_wr),
    .busy_o  (ks_busy)
  );

  // Round r: read high half at phase 0, low at phase 1, apply at phase 2.
  assign rd_addr = {rnd_q, ph_q[0]};

  always_ff @(posedge clk_i) begin
    if (ks_wr.wr) rk_mem[ks_wr.addr] <= ks_wr.data;
    rk_q <= rk_mem[rd_addr];
  end

  assign last_round = (rnd_q == 4'd0);
  assign ark = st_q ^ {kh_q, rk_q};

  always_comb begin
    logic [7:0] a0, a1, a2, a3;
    mix = ark;
    for (int c = 0; c < 4; c++) begin
      a0 = ark[127-32*c -: 8];
      a1 = ark[119-32*c -: 8];
      a2 = ark[111-32*c -: 8];
      a3 = ark[103-32*c -: 8];
      mix[127-32*c -: 8] = aesd_pkg::gmul(a0, 8'd14) ^ aesd_pkg::gmul(a1, 8'd11)
                         ^ aesd_pkg::gmul(a2, 8'd13) ^ aesd_pkg::gmul(a3, 8'd9);
      mix[119-32*c -: 8] = aesd_pkg::gmul(a0, 8'd9) ^ aesd_pkg::gmul(a1, 8'd14)
                         ^ aesd_pkg::gmul(a2, 8'd11) ^ aesd_pkg::gmul(a3, 8'd13);
      mix[111-32*c -: 8] = aesd_pkg::gmul(a0, 8'd13) ^ aesd_pkg::gmul(a1, 8'd9)
                         ^ aesd_pkg::gmul(a2, 8'd14) ^ aesd_pkg::gmul(a3, 8'd11);
      mix[103-32*c -: 8] = aesd_pkg::gmul(a0, 8'd11) ^ aesd_pkg::gmul(a1, 8'd13)
                         ^ aesd_pkg::gmul(a2, 8'd9) ^ aesd_pkg::gmul(a3, 8'd14);
    end
  end

  always_comb begin
    logic [127:0] src;
    src = (state_q == aesd_pkg::ST_FIRST) ? ark : mix;
    for (int i = 0; i < 16; i++) begin
      shs[127-8*i -: 8] = aesd_pkg::ISBOX[src[127-8*aesd_pkg::SHIFT_SRC[i] -: 8]];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      aesd_pkg::ST_IDLE:  if (in_valid_i) state_d = aesd_pkg::ST_FIRST;
      aesd_pkg::ST_FIRST: if (ph_q == 2'd2) state_d = aesd_pkg::ST_ROUND;
      aesd_pkg::ST_ROUND: if (ph_q == 2'd2 && last_round) state_d = aesd_pkg::ST_DONE;
      aesd_pkg::ST_DONE:  if (!out_stall_i) state_d = aesd_pkg::ST_IDLE;
      default:            state_d = aesd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    st_d = st_q;
    rnd_d = rnd_q;
    ph_d = ph_q;
    case (state_q)
      aesd_pkg::ST_IDLE: begin
        st_d = in_data_i;
        rnd_d = 4'(aesd_pkg::NumRounds);
        ph_d = '0;
      end
      aesd_pkg::ST_FIRST, aesd_pkg::ST_ROUND: begin
        if (ph_q == 2'd2) begin
          ph_d = '0;
          if (state_q == aesd_pkg::ST_ROUND && last_round) st_d = ark;
          else begin
            st_d = shs;
            rnd_d = rnd_q - 4'd1;
          end
        end else begin
          ph_d = ph_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != aesd_pkg::ST_IDLE) || ks_busy;
    out_valid_o = (state_q == aesd_pkg::ST_DONE);
    out_data_o = st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aesd_pkg::ST_IDLE;
      rnd_q <= '0;
      ph_q <= '0;
    end else begin
      state_q <= (state_q == aesd_pkg::ST_IDLE && ks_busy) ? aesd_pkg::ST_IDLE : state_d;
      rnd_q <= rnd_d;
      ph_q <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    if (ph_q == 2'd1) kh_q <= rk_q;
  end

endmodule
`default_nettype wire

### hdl/aesd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "aes128_block_decrypt_assert.svh"
module aesd_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire aesd_pkg::out_beat_t  out_data_o
);

  `AES_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))
  `AES_ASSERT_IMPL(a_no_take_while_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  `AES_ASSERT_NEXT(a_take_busy, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o && !out_valid_o)

endmodule

bind aes128_block_decrypt aesd_checker u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
